FILE: rtl/core/rtt_pkg.sv
`timescale 1ns / 1ps

package rtt_pkg;

  // Input action codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_DEL    = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  // Ignored: no result and no scan, but the inputs are captured and the fire count cleared
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // A count of one means the slot fires a final time and is freed
  localparam logic [15:0] REPEAT_ONCE = 16'd1;

  // Saturation value of the per-tick fire count
  localparam logic [4:0] FIRE_CNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_SUM   = 2'd3
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_in;    // capture input transaction, clear fire count
    logic       wr_add;     // write new timer at addr, set valid, bump reference
    logic       wr_fire;    // fired slot: re-arm or free, bump fire count
    logic       clr_valid;  // delete slot at addr
    logic       emit;       // load output register
    kind_t      kind;
    logic [1:0] status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;  // slot at addr is free
    logic ref_hit;    // slot at addr valid and holds the requested reference
    logic due_hit;    // slot at addr valid and due
    logic out_free;   // output register can take a result this cycle
  } sts_t;

endpackage

FILE: rtl/core/rtt_ctrl.sv
`timescale 1ns / 1ps

module rtt_ctrl #(
  parameter int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  rtt_pkg::sts_t     sts,
  output rtt_pkg::cmd_t     cmd,
  output logic [IDX_W-1:0]  addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RD,
    S_EVAL,
    S_DONE
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [1:0]        op, op_next;
  logic              last_idx;

  assign last_idx = (idx == IDX_W'(SLOTS - 1));
  assign in_ready = (state == S_IDLE);
  assign addr     = idx;

  always_comb begin
    cmd        = '0;
    state_next = state;
    idx_next   = idx;
    op_next    = op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          op_next     = action;
          idx_next    = '0;
          case (action)
            rtt_pkg::ACT_ADD:  state_next = S_ADD;
            rtt_pkg::ACT_DEL:  state_next = S_RD;
            rtt_pkg::ACT_TICK: state_next = S_RD;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (sts.slot_free) begin
          if (sts.out_free) begin
            cmd.wr_add = 1'b1;
            cmd.emit   = 1'b1;
            cmd.kind   = rtt_pkg::KIND_ADD;
            cmd.status = rtt_pkg::ST_OK;
            state_next = S_IDLE;
          end
        end else if (last_idx) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_RD: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (op == rtt_pkg::ACT_DEL) begin
          if (sts.ref_hit) begin
            if (sts.out_free) begin
              cmd.clr_valid = 1'b1;
              cmd.emit      = 1'b1;
              cmd.kind      = rtt_pkg::KIND_DEL;
              cmd.status    = rtt_pkg::ST_OK;
              state_next    = S_IDLE;
            end
          end else if (last_idx) begin
            state_next = S_DONE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = S_RD;
          end
        end else begin
          if (sts.due_hit && !sts.out_free) begin
            state_next = S_EVAL;
          end else begin
            if (sts.due_hit) begin
              cmd.wr_fire = 1'b1;
              cmd.emit    = 1'b1;
              cmd.kind    = rtt_pkg::KIND_FIRED;
              cmd.status  = rtt_pkg::ST_OK;
            end
            if (last_idx) begin
              state_next = S_DONE;
            end else begin
              idx_next   = idx + IDX_W'(1);
              state_next = S_RD;
            end
          end
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          case (op)
            rtt_pkg::ACT_ADD: begin
              cmd.kind   = rtt_pkg::KIND_ADD;
              cmd.status = rtt_pkg::ST_FULL;
            end
            rtt_pkg::ACT_DEL: begin
              cmd.kind   = rtt_pkg::KIND_DEL;
              cmd.status = rtt_pkg::ST_NOT_FOUND;
            end
            default: begin
              cmd.kind   = rtt_pkg::KIND_SUM;
              cmd.status = rtt_pkg::ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      op    <= rtt_pkg::ACT_ADD;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      op    <= op_next;
    end
  end

endmodule

FILE: rtl/core/rtt_datapath.sv
`timescale 1ns / 1ps

module rtt_datapath #(
  parameter int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  rtt_pkg::cmd_t     cmd,
  input  logic [IDX_W-1:0]  addr,
  output rtt_pkg::sts_t     sts,
  input  logic [31:0]       current_time,
  input  logic [31:0]       interval,
  input  logic [15:0]       repeat_count,
  input  logic [15:0]       ref_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [15:0]       ref_number_out,
  output logic [1:0]        status,
  output logic [4:0]        fired_count,
  output logic              last
);

  // Slot storage, no reset; reads are registered at addr
  logic [31:0] mem_ivl [SLOTS];
  logic [31:0] mem_lf  [SLOTS];
  logic [15:0] mem_rem [SLOTS];
  logic [15:0] mem_ref [SLOTS];

  logic [31:0] rd_ivl, rd_lf;
  logic [15:0] rd_rem, rd_ref;

  logic [SLOTS-1:0] valid;
  logic [15:0]      next_ref;
  logic [4:0]       fire_cnt;

  // Captured input transaction
  logic [31:0] in_now, in_ivl;
  logic [15:0] in_cnt, in_ref;

  logic [31:0] due;
  logic [15:0] rem_dec;
  logic [15:0] ref_sel;

  assign due     = rd_lf + rd_ivl;
  assign rem_dec = (rd_rem > rtt_pkg::REPEAT_ONCE) ? (rd_rem - 16'd1) : rd_rem;

  assign sts.slot_free = !valid[addr];
  assign sts.ref_hit   = valid[addr] && (rd_ref == in_ref);
  assign sts.due_hit   = valid[addr] && (due <= in_now);
  assign sts.out_free  = !out_valid || out_ready;

  always_comb begin
    case (cmd.kind)
      rtt_pkg::KIND_ADD:   ref_sel = next_ref;
      rtt_pkg::KIND_FIRED: ref_sel = rd_ref;
      default:             ref_sel = 16'd0;
    endcase
    if (cmd.status != rtt_pkg::ST_OK) begin
      ref_sel = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_add) begin
      mem_ivl[addr] <= in_ivl;
      mem_lf[addr]  <= in_now;
      mem_rem[addr] <= in_cnt;
      mem_ref[addr] <= next_ref;
    end else if (cmd.wr_fire) begin
      mem_lf[addr]  <= in_now;
      mem_rem[addr] <= rem_dec;
    end
    rd_ivl <= mem_ivl[addr];
    rd_lf  <= mem_lf[addr];
    rd_rem <= mem_rem[addr];
    rd_ref <= mem_ref[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      next_ref  <= 16'd0;
      fire_cnt  <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.wr_add) begin
        valid[addr] <= 1'b1;
        next_ref    <= next_ref + 16'd1;
      end
      if (cmd.clr_valid || (cmd.wr_fire && (rd_rem == rtt_pkg::REPEAT_ONCE))) begin
        valid[addr] <= 1'b0;
      end
      if (cmd.load_in) begin
        fire_cnt <= 5'd0;
      end else if (cmd.wr_fire && (fire_cnt != rtt_pkg::FIRE_CNT_MAX)) begin
        fire_cnt <= fire_cnt + 5'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_now <= current_time;
      in_ivl <= interval;
      in_cnt <= repeat_count;
      in_ref <= ref_number;
    end
    if (cmd.emit) begin
      kind           <= cmd.kind;
      status         <= cmd.status;
      ref_number_out <= ref_sel;
      fired_count    <= (cmd.kind == rtt_pkg::KIND_SUM) ? fire_cnt : 5'd0;
      last           <= (cmd.kind != rtt_pkg::KIND_FIRED);
    end
  end

endmodule

FILE: rtl/core/repeating_timer_table_top.sv
`timescale 1ns / 1ps
// Throughput: one transaction in flight; the next is taken the cycle after the last result
// is queued. A tick visits each slot as a registered slot read, then compare and write
// back; output stalls hold the scan.
// Reset: synchronous, clears slot valid bits, reference counter, controller and output valid.

module repeating_timer_table_top #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] current_time,
  input  logic [31:0] interval,
  input  logic [15:0] repeat_count,
  input  logic [15:0] ref_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] ref_number_out,
  output logic [1:0]  status,
  output logic [4:0]  fired_count,
  output logic        last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Controller/datapath handshake
  rtt_pkg::cmd_t     cmd;
  rtt_pkg::sts_t     sts;
  logic [IDX_W-1:0]  addr;

  // Controller: walks the slot index, sequences add / delete / tick scans,
  // and decides when a result transaction is emitted.
  rtt_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  // Datapath: slot memories, valid bits, reference counter, due compare,
  // fire counter and the output register that decouples the result side.
  rtt_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .addr           (addr),
    .sts            (sts),
    .current_time   (current_time),
    .interval       (interval),
    .repeat_count   (repeat_count),
    .ref_number     (ref_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .ref_number_out (ref_number_out),
    .status         (status),
    .fired_count    (fired_count),
    .last           (last)
  );

  // Only fired results are non-final
  a_nonlast_is_fired: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> kind == rtt_pkg::KIND_FIRED)
    else $error("non-final result that is not a fired timer");

  // Fire count only appears on the tick summary
  a_count_on_summary: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != rtt_pkg::KIND_SUM |-> fired_count == 5'd0)
    else $error("fired_count set on a non-summary result");

  // An unused action leaves the block ready in the next cycle
  a_unused_action: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == rtt_pkg::ACT_UNUSED |=> in_ready)
    else $error("unused action left the block busy");

  // Summary always reports ok and closes the transaction
  a_summary_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == rtt_pkg::KIND_SUM |-> last && status == rtt_pkg::ST_OK)
    else $error("malformed tick summary");

endmodule
